// ===== rtl/core/dts_pkg.sv =====
`timescale 1ns / 1ps

package dts_pkg;

  // Table sizing
  localparam int MAX_TASKS  = 32;
  localparam int SLOT_SPACE = 32;
  localparam int SLOT_LIMIT = (MAX_TASKS > SLOT_SPACE) ? SLOT_SPACE : MAX_TASKS;
  localparam int SLOT_W     = 5;
  localparam int IDX_W      = SLOT_W + 1;
  localparam int TICK_W     = 64;
  localparam int HOLD_W     = 16;

  localparam logic [IDX_W-1:0] SLOT_LIMIT_V = IDX_W'(SLOT_LIMIT);

  // Stream widths, fields packed from bit 0 and padded to whole bytes
  localparam int OP_W       = 4;
  localparam int IN_FIELD_W = SLOT_W + 1 + TICK_W + TICK_W;
  localparam int IN_DATA_W  = ((IN_FIELD_W + 7) / 8) * 8;
  localparam int OUT_FIELD_W = SLOT_W + 1 + 1 + TICK_W + SLOT_W + 1;
  localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_REGISTER   = 4'd0,
    OP_UNREGISTER = 4'd1,
    OP_PLAN_ZERO  = 4'd2,
    OP_PLAN_ABS   = 4'd3,
    OP_PLAN_SPIN  = 4'd4,
    OP_PLAN_NOW   = 4'd5,
    OP_RUN        = 4'd6,
    OP_HOLD       = 4'd7,
    OP_RELEASE    = 4'd8
  } op_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic exec;        // apply a non-run operation and load its result
    logic scan_start;  // latch spin time and read slot 0
    logic adv;         // step the scan to the next slot
    logic take;        // dispatch the slot under check
    logic flush;       // load the closing result of a run pass
  } dts_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic chk_valid;
    logic chk_due;
    logic have_pend;
    logic out_free;
  } dts_stat_t;

endpackage

// ===== rtl/core/dts_ctrl.sv =====
`timescale 1ns / 1ps

module dts_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [dts_pkg::OP_W-1:0] opcode,
  input  dts_pkg::dts_stat_t     stat,
  output dts_pkg::dts_cmd_t      cmd
);
  import dts_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_FLUSH = 3'b100
  } state_t;

  state_t state, state_next;
  logic   stall;

  // Hold a due slot while the previous dispatch still waits for the output
  assign stall = stat.chk_valid & stat.chk_due & stat.have_pend & ~stat.out_free;

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = stat.out_free;
        if (s_tvalid && stat.out_free) begin
          if (opcode == OP_RUN) begin
            cmd.scan_start = 1'b1;
            state_next     = S_SCAN;
          end else begin
            cmd.exec = 1'b1;
          end
        end
      end
      S_SCAN: begin
        if (stat.chk_valid) begin
          cmd.adv  = ~stall;
          cmd.take = stat.chk_due & ~stall;
        end else begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (stat.out_free) begin
          cmd.flush  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/core/dts_dpath.sv =====
`timescale 1ns / 1ps

module dts_dpath (
  input  logic                       clk,
  input  logic                       rst,
  input  dts_pkg::dts_cmd_t          cmd,
  output dts_pkg::dts_stat_t         stat,
  input  logic [dts_pkg::OP_W-1:0]   opcode,
  input  logic [dts_pkg::SLOT_W-1:0] slot_sel,
  input  logic                       use_current,
  input  logic [dts_pkg::TICK_W-1:0] tick_amount,
  input  logic [dts_pkg::TICK_W-1:0] time_now,
  input  logic                       m_tready,
  output logic                       m_tvalid,
  output logic                       m_tlast,
  output logic [dts_pkg::SLOT_W-1:0] slot_out,
  output logic                       slot_due,
  output logic                       status,
  output logic [dts_pkg::TICK_W-1:0] spin_time,
  output logic [dts_pkg::SLOT_W-1:0] current_slot,
  output logic                       sleep_allowed
);
  import dts_pkg::*;

  function automatic logic [SLOT_SPACE-1:0] limit_mask();
    logic [SLOT_SPACE-1:0] m;
    m = '0;
    for (int i = 0; i < SLOT_SPACE; i++) begin
      m[i] = (i < SLOT_LIMIT);
    end
    return m;
  endfunction

  // Lowest set bit
  function automatic logic [SLOT_W-1:0] low_bit(input logic [SLOT_SPACE-1:0] v);
    logic [SLOT_W-1:0] pos;
    pos = '0;
    for (int i = SLOT_SPACE - 1; i >= 0; i--) begin
      if (v[i]) pos = SLOT_W'(i);
    end
    return pos;
  endfunction

  // Highest set bit, zero when none
  function automatic logic [SLOT_W-1:0] high_bit(input logic [SLOT_SPACE-1:0] v);
    logic [SLOT_W-1:0] pos;
    pos = '0;
    for (int i = 0; i < SLOT_SPACE; i++) begin
      if (v[i]) pos = SLOT_W'(i);
    end
    return pos;
  endfunction

  localparam logic [SLOT_SPACE-1:0] LIMIT_MASK = limit_mask();

  // Deadline memory: one write and one registered read per cycle
  logic [TICK_W-1:0] dl_mem [SLOT_SPACE];
  logic [TICK_W-1:0] rd_data;

  // Scheduler state
  logic [SLOT_SPACE-1:0] slot_valid;
  logic [SLOT_W-1:0]     highest_used;
  logic [SLOT_W-1:0]     dispatched;
  logic [TICK_W-1:0]     spin_tick;
  logic [HOLD_W-1:0]     hold_cnt;

  // Scan pipeline
  logic [IDX_W-1:0]  rd_idx;
  logic [SLOT_W-1:0] chk_idx;
  logic              chk_valid;
  logic              have_pend;
  logic [SLOT_W-1:0] pend_slot;

  // Non-run operation decode
  logic [SLOT_SPACE-1:0] free_vec;
  logic                  free_found;
  logic [SLOT_W-1:0]     free_slot;
  logic [SLOT_SPACE-1:0] sel_bit;
  logic [SLOT_SPACE-1:0] valid_clr;
  logic [SLOT_W-1:0]     lower_top;
  logic                  sel_ok;
  logic [SLOT_W-1:0]     target;
  logic                  target_ok;
  logic [HOLD_W-1:0]     hold_next;

  logic              wr_en;
  logic [SLOT_W-1:0] wr_addr;
  logic [TICK_W-1:0] wr_data;
  logic              rd_en;
  logic [SLOT_W-1:0] rd_addr;

  logic              out_free;
  logic              out_load;
  logic [SLOT_W-1:0] ld_slot;
  logic              ld_due;
  logic              ld_status;
  logic              ld_last;
  logic [SLOT_W-1:0] ld_current;
  logic              ld_sleep;

  assign free_vec   = ~slot_valid & LIMIT_MASK;
  assign free_found = |free_vec;
  assign free_slot  = low_bit(free_vec);
  assign sel_bit    = SLOT_SPACE'(1) << slot_sel;
  assign valid_clr  = slot_valid & ~sel_bit;
  assign lower_top  = high_bit(valid_clr & (sel_bit - SLOT_SPACE'(1)));
  assign sel_ok     = {1'b0, slot_sel} < SLOT_LIMIT_V;
  assign target     = use_current ? dispatched : slot_sel;
  assign target_ok  = {1'b0, target} < SLOT_LIMIT_V;

  // Saturating sleep-hold count
  always_comb begin
    hold_next = hold_cnt;
    if (opcode == OP_HOLD && hold_cnt != '1) hold_next = hold_cnt + HOLD_W'(1);
    if (opcode == OP_RELEASE && hold_cnt != '0) hold_next = hold_cnt - HOLD_W'(1);
  end

  // Select the memory write
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = chk_idx;
    wr_data = '1;
    if (cmd.take) begin
      wr_en = 1'b1;
    end else if (cmd.exec) begin
      wr_addr = target;
      case (opcode)
        OP_REGISTER: begin
          wr_en   = free_found;
          wr_addr = free_slot;
          wr_data = tick_amount;
        end
        OP_PLAN_ZERO: begin
          wr_en   = target_ok;
          wr_data = '0;
        end
        OP_PLAN_ABS: begin
          wr_en   = target_ok;
          wr_data = tick_amount;
        end
        OP_PLAN_SPIN: begin
          wr_en   = target_ok;
          wr_data = spin_tick + tick_amount;
        end
        OP_PLAN_NOW: begin
          wr_en   = target_ok;
          wr_data = time_now + tick_amount;
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end
  end

  assign rd_en   = cmd.scan_start | cmd.adv;
  assign rd_addr = cmd.scan_start ? '0 : rd_idx[SLOT_W-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) dl_mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= dl_mem[rd_addr];
  end

  // Status toward the controller
  assign out_free       = ~m_tvalid | m_tready;
  assign stat.chk_valid = chk_valid;
  assign stat.chk_due   = chk_valid & slot_valid[chk_idx] & (spin_tick >= rd_data);
  assign stat.have_pend = have_pend;
  assign stat.out_free  = out_free;

  // Table and counter updates
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid   <= '0;
      highest_used <= '0;
      dispatched   <= '0;
      spin_tick    <= '0;
      hold_cnt     <= '0;
    end else begin
      if (cmd.exec) begin
        hold_cnt <= hold_next;
        case (opcode)
          OP_REGISTER: begin
            if (free_found) begin
              slot_valid[free_slot] <= 1'b1;
              if (free_slot > highest_used) highest_used <= free_slot;
            end
          end
          OP_UNREGISTER: begin
            if (sel_ok) begin
              slot_valid <= valid_clr;
              if (highest_used == slot_sel) highest_used <= lower_top;
            end
          end
          default: begin
          end
        endcase
      end
      if (cmd.scan_start) spin_tick <= time_now;
      if (cmd.take) dispatched <= chk_idx;
    end
  end

  // Advance the scan one slot per cycle while it is not stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx    <= '0;
      chk_idx   <= '0;
      chk_valid <= 1'b0;
      have_pend <= 1'b0;
      pend_slot <= '0;
    end else begin
      if (cmd.scan_start) begin
        rd_idx    <= IDX_W'(1);
        chk_idx   <= '0;
        chk_valid <= 1'b1;
        have_pend <= 1'b0;
      end else if (cmd.adv) begin
        rd_idx    <= rd_idx + IDX_W'(1);
        chk_idx   <= rd_idx[SLOT_W-1:0];
        chk_valid <= rd_idx <= {1'b0, highest_used};
      end
      if (cmd.take) begin
        have_pend <= 1'b1;
        pend_slot <= chk_idx;
      end
      if (cmd.flush) have_pend <= 1'b0;
    end
  end

  // Build the next result
  always_comb begin
    out_load   = 1'b0;
    ld_slot    = '0;
    ld_due     = 1'b0;
    ld_status  = 1'b0;
    ld_last    = 1'b1;
    ld_current = dispatched;
    ld_sleep   = (hold_cnt == '0);
    if (cmd.exec) begin
      out_load  = 1'b1;
      ld_sleep  = (hold_next == '0);
      if (opcode == OP_REGISTER) begin
        ld_slot   = free_found ? free_slot : '0;
        ld_status = ~free_found;
      end
    end else if (cmd.take && have_pend) begin
      out_load   = 1'b1;
      ld_slot    = pend_slot;
      ld_due     = 1'b1;
      ld_last    = 1'b0;
      ld_current = pend_slot;
    end else if (cmd.flush) begin
      out_load = 1'b1;
      if (have_pend) begin
        ld_slot    = pend_slot;
        ld_due     = 1'b1;
        ld_current = pend_slot;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      slot_out      <= ld_slot;
      slot_due      <= ld_due;
      status        <= ld_status;
      m_tlast       <= ld_last;
      spin_time     <= cmd.scan_start ? time_now : spin_tick;
      current_slot  <= ld_current;
      sleep_allowed <= ld_sleep;
    end
  end

endmodule

// ===== rtl/core/deadline_task_scheduler.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Signals                        Moves
// s_*       in   tvalid tready tdata tuser      one command transfer
// m_*       out  tvalid tready tdata tlast      one result transfer
//
// Non-run commands give one result each.
// A run pass scans up to the highest used slot: the deadline memory has one
// read port, so the scan checks one slot per cycle while it is not stalled.
// A stalled output holds the scan only when a second due slot is found.
// Reset is synchronous; no clearing pass is needed, the table starts empty.
module deadline_task_scheduler (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // slot_sel[4:0], use_current[5], tick_amount[69:6], time_now[133:70]
  input  logic [dts_pkg::IN_DATA_W-1:0]     s_tdata,
  // opcode[3:0]
  input  logic [dts_pkg::OP_W-1:0]          s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // slot_out[4:0], slot_due[5], status[6], spin_time[70:7],
  // current_slot[75:71], sleep_allowed[76]
  output logic [dts_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic                              m_tlast
);
  import dts_pkg::*;

  dts_cmd_t          cmd;
  dts_stat_t         stat;
  logic [SLOT_W-1:0] slot_out;
  logic              slot_due;
  logic              status;
  logic [TICK_W-1:0] spin_time;
  logic [SLOT_W-1:0] current_slot;
  logic              sleep_allowed;

  dts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .opcode   (s_tuser),
    .stat     (stat),
    .cmd      (cmd)
  );

  dts_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .opcode        (s_tuser),
    .slot_sel      (s_tdata[SLOT_W-1:0]),
    .use_current   (s_tdata[SLOT_W]),
    .tick_amount   (s_tdata[SLOT_W+1 +: TICK_W]),
    .time_now      (s_tdata[SLOT_W+1+TICK_W +: TICK_W]),
    .m_tready      (m_tready),
    .m_tvalid      (m_tvalid),
    .m_tlast       (m_tlast),
    .slot_out      (slot_out),
    .slot_due      (slot_due),
    .status        (status),
    .spin_time     (spin_time),
    .current_slot  (current_slot),
    .sleep_allowed (sleep_allowed)
  );

  assign m_tdata = {(OUT_DATA_W - OUT_FIELD_W)'(0), sleep_allowed, current_slot,
                    spin_time, status, slot_due, slot_out};

endmodule

// ===== rtl/core/dts_checker.sv =====
`timescale 1ns / 1ps

module dts_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [dts_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                           m_tlast
);
  import dts_pkg::*;

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  // Nothing is offered right after reset
  a_reset: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("result offered after reset");

  // A result that names no due slot always closes its command
  a_nodue_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[SLOT_W] |-> m_tlast)
    else $error("non-dispatch result without tlast");

  // A full-table report carries no slot
  a_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[SLOT_W+1] |-> m_tdata[SLOT_W-1:0] == '0 && !m_tdata[SLOT_W])
    else $error("full-table result names a slot");

  // A dispatched slot becomes the current slot
  a_current: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[SLOT_W] |->
      m_tdata[SLOT_W+2+TICK_W +: SLOT_W] == m_tdata[SLOT_W-1:0])
    else $error("current slot differs from dispatched slot");

endmodule

bind deadline_task_scheduler dts_checker u_dts_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import dts_pkg::*;

  // Opcodes outside the defined set; the block must treat them as no-ops
  localparam logic [OP_W-1:0]   OP_FIRST_UNKNOWN = 4'd9;
  localparam logic [OP_W-1:0]   OP_LAST_UNKNOWN  = 4'd15;
  localparam logic [HOLD_W-1:0] HOLD_MAX         = '1;
  localparam int                TAIL_CYCLES      = 2 * SLOT_SPACE + 16;

  typedef struct packed {
    logic [SLOT_W-1:0] slot_out;
    logic              slot_due;
    logic              status;
    logic              last_flag;
    logic [TICK_W-1:0] spin_time;
    logic [SLOT_W-1:0] current_slot;
    logic              sleep_allowed;
  } sched_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [OP_W-1:0]       s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;

  // Scheduler state as predicted from the accepted commands
  logic [TICK_W-1:0] mdl_deadline [SLOT_SPACE];
  logic              mdl_valid [SLOT_SPACE];
  logic [TICK_W-1:0] mdl_spin = '0;
  logic [SLOT_W-1:0] mdl_current = '0;
  logic [SLOT_W-1:0] mdl_highest = '0;
  logic [HOLD_W-1:0] mdl_hold = '0;

  sched_result_t pending_results[$];
  int            err_count = 0;
  int            send_idle_pct = 0;
  int            rcv_stall_pct = 0;
  int            hold_off_left = 0;
  logic [TICK_W-1:0] now_base = '0;

  deadline_task_scheduler u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    for (int i = 0; i < SLOT_SPACE; i++) begin
      mdl_deadline[i] = '0;
      mdl_valid[i]    = 1'b0;
    end
  end

  // Build one result from the predicted state after its update
  function automatic void push_result(input logic [SLOT_W-1:0] slot, input logic due,
                                      input logic st, input logic lst);
    sched_result_t r;
    r.slot_out      = slot;
    r.slot_due      = due;
    r.status        = st;
    r.last_flag     = lst;
    r.spin_time     = mdl_spin;
    r.current_slot  = mdl_current;
    r.sleep_allowed = (mdl_hold == '0);
    pending_results.push_back(r);
  endfunction

  // Apply one command to the predicted state and queue its results
  task automatic predict_sched(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] sel,
                               input logic use_cur, input logic [TICK_W-1:0] amount,
                               input logic [TICK_W-1:0] now);
    logic [SLOT_W-1:0] target;
    bit                found;
    bit                stop;
    int                last_due;
    target = use_cur ? mdl_current : sel;
    case (op)
      OP_REGISTER: begin
        found = 1'b0;
        for (int i = 0; i < SLOT_LIMIT; i++) begin
          if (!found && !mdl_valid[i]) begin
            found           = 1'b1;
            mdl_valid[i]    = 1'b1;
            mdl_deadline[i] = amount;
            if (mdl_highest < i) mdl_highest = i[SLOT_W-1:0];
            push_result(i[SLOT_W-1:0], 1'b0, 1'b0, 1'b1);
          end
        end
        if (!found) push_result('0, 1'b0, 1'b1, 1'b1);
      end
      OP_UNREGISTER: begin
        if (sel < SLOT_LIMIT) begin
          mdl_valid[sel] = 1'b0;
          // Lower the highest index past free slots, stopping at zero
          if (mdl_highest == sel) begin
            stop = 1'b0;
            while (!stop) begin
              if (mdl_highest == '0) begin
                stop = 1'b1;
              end else begin
                mdl_highest = mdl_highest - SLOT_W'(1);
                if (mdl_valid[mdl_highest]) stop = 1'b1;
              end
            end
          end
        end
        push_result('0, 1'b0, 1'b0, 1'b1);
      end
      OP_PLAN_ZERO, OP_PLAN_ABS, OP_PLAN_SPIN, OP_PLAN_NOW: begin
        if (target < SLOT_LIMIT) begin
          case (op)
            OP_PLAN_ZERO: mdl_deadline[target] = '0;
            OP_PLAN_ABS:  mdl_deadline[target] = amount;
            OP_PLAN_SPIN: mdl_deadline[target] = mdl_spin + amount;
            default:      mdl_deadline[target] = now + amount;
          endcase
        end
        push_result('0, 1'b0, 1'b0, 1'b1);
      end
      OP_RUN: begin
        mdl_spin = now;
        // Due checks are per slot, so find the final due slot up front
        last_due = -1;
        for (int i = 0; i <= mdl_highest && i < SLOT_LIMIT; i++) begin
          if (mdl_valid[i] && mdl_spin >= mdl_deadline[i]) last_due = i;
        end
        if (last_due < 0) begin
          push_result('0, 1'b0, 1'b0, 1'b1);
        end else begin
          for (int i = 0; i <= last_due; i++) begin
            if (mdl_valid[i] && mdl_spin >= mdl_deadline[i]) begin
              mdl_deadline[i] = '1;
              mdl_current     = i[SLOT_W-1:0];
              push_result(i[SLOT_W-1:0], 1'b1, 1'b0, i == last_due);
            end
          end
        end
      end
      OP_HOLD: begin
        if (mdl_hold != HOLD_MAX) mdl_hold = mdl_hold + HOLD_W'(1);
        push_result('0, 1'b0, 1'b0, 1'b1);
      end
      OP_RELEASE: begin
        if (mdl_hold != '0) mdl_hold = mdl_hold - HOLD_W'(1);
        push_result('0, 1'b0, 1'b0, 1'b1);
      end
      default: begin
        push_result('0, 1'b0, 1'b0, 1'b1);
      end
    endcase
  endtask

  // Offer one command, hold it until the transfer, then predict it
  task automatic send_cmd(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] sel,
                          input logic use_cur, input logic [TICK_W-1:0] amount,
                          input logic [TICK_W-1:0] now);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {{(IN_DATA_W - IN_FIELD_W){1'b0}}, now, amount, use_cur, sel};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_sched(op, sel, use_cur, amount, now);
  endtask

  // Pause the sender until every queued result has come out
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_pacing(input int idle_pct, input int stall_pct);
    send_idle_pct = idle_pct;
    rcv_stall_pct = stall_pct;
  endtask

  function automatic logic [TICK_W-1:0] pick_tick(input logic [TICK_W-1:0] around);
    case ($urandom_range(9))
      0:       return {$urandom, $urandom};
      1:       return '1;
      2:       return '0;
      default: return around + TICK_W'($urandom_range(120));
    endcase
  endfunction

  // Mostly coherent traffic around a drifting tick, with some full-range noise
  task automatic drive_random_cmds(input int count);
    logic [OP_W-1:0]   op;
    logic [SLOT_W-1:0] sel;
    logic              use_cur;
    logic [TICK_W-1:0] amt;
    logic [TICK_W-1:0] now;
    int                pick;
    for (int k = 0; k < count; k++) begin
      pick    = $urandom_range(99);
      sel     = SLOT_W'($urandom_range(SLOT_SPACE - 1));
      use_cur = ($urandom_range(9) < 3);
      amt     = {$urandom, $urandom};
      now     = {$urandom, $urandom};
      if ($urandom_range(3) == 0) now_base = now_base + TICK_W'($urandom_range(80));
      if (pick < 18) begin
        op  = OP_REGISTER;
        amt = pick_tick(now_base);
      end else if (pick < 28) begin
        op = OP_UNREGISTER;
      end else if (pick < 36) begin
        op = OP_PLAN_ZERO;
      end else if (pick < 46) begin
        op  = OP_PLAN_ABS;
        amt = pick_tick(now_base);
      end else if (pick < 54) begin
        op = OP_PLAN_SPIN;
        if ($urandom_range(4) != 0) amt = TICK_W'($urandom_range(150));
      end else if (pick < 62) begin
        op = OP_PLAN_NOW;
        if ($urandom_range(4) != 0) begin
          amt = TICK_W'($urandom_range(150));
          now = now_base;
        end
      end else if (pick < 82) begin
        op = OP_RUN;
        if ($urandom_range(9) != 0) now = now_base;
      end else if (pick < 88) begin
        op = OP_HOLD;
      end else if (pick < 94) begin
        op = OP_RELEASE;
      end else if (pick < 97) begin
        op = OP_W'($urandom_range(OP_LAST_UNKNOWN, OP_FIRST_UNKNOWN));
      end else begin
        op  = OP_REGISTER;
        amt = pick_tick(now_base);
      end
      send_cmd(op, sel, use_cur, amt, now);
    end
  endtask

  // Every opcode, wrapping plans, free slots, empty pass and counter floor
  task automatic test_basic_ops();
    set_pacing(0, 0);
    send_cmd(OP_RUN,        5'd0,  1'b0, '0,          '0);
    send_cmd(OP_REGISTER,   5'd31, 1'b1, '0,          '1);
    send_cmd(OP_REGISTER,   5'd0,  1'b0, '1,          '0);
    send_cmd(OP_REGISTER,   5'd0,  1'b0, 64'd100,     '0);
    send_cmd(OP_RUN,        5'd0,  1'b0, '0,          64'd50);
    send_cmd(OP_PLAN_ZERO,  5'd7,  1'b1, '1,          '1);
    send_cmd(OP_PLAN_ABS,   5'd2,  1'b0, 64'd40,      '0);
    send_cmd(OP_PLAN_SPIN,  5'd1,  1'b0, '1,          '0);
    send_cmd(OP_PLAN_NOW,   5'd3,  1'b0, 64'd5,       '1);
    send_cmd(OP_RUN,        5'd0,  1'b0, '0,          64'd45);
    send_cmd(OP_RUN,        5'd0,  1'b0, '0,          '1);
    send_cmd(OP_UNREGISTER, 5'd3,  1'b0, '0,          '0);
    send_cmd(OP_UNREGISTER, 5'd2,  1'b0, '0,          '0);
    send_cmd(OP_REGISTER,   5'd0,  1'b0, 64'hFFFF_FFFF_0000_0000, '0);
    send_cmd(OP_PLAN_SPIN,  5'd0,  1'b1, 64'd1,       '0);
    send_cmd(OP_RELEASE,    5'd0,  1'b0, '0,          '0);
    send_cmd(OP_HOLD,       5'd0,  1'b0, '0,          '0);
    send_cmd(OP_HOLD,       5'd0,  1'b0, '0,          '0);
    send_cmd(OP_RELEASE,    5'd0,  1'b0, '0,          '0);
    send_cmd(OP_RELEASE,    5'd0,  1'b0, '0,          '0);
    send_cmd(OP_RELEASE,    5'd0,  1'b0, '0,          '0);
    send_cmd(OP_FIRST_UNKNOWN, 5'd31, 1'b1, '1,       '1);
    send_cmd(OP_LAST_UNKNOWN,  5'd31, 1'b1, '1,       '1);
    send_cmd(OP_UNREGISTER, 5'd31, 1'b0, '0,          '0);
    drain_results();
  endtask

  // Fill the table past full, dispatch every slot at once, then empty it
  task automatic test_full_table();
    set_pacing(23, 23);
    repeat (SLOT_SPACE + 2) send_cmd(OP_REGISTER, '0, 1'b0, pick_tick(now_base), '0);
    send_cmd(OP_RUN, '0, 1'b0, '0, '1);
    send_cmd(OP_UNREGISTER, 5'd31, 1'b0, '0, '0);
    send_cmd(OP_UNREGISTER, 5'd15, 1'b0, '0, '0);
    send_cmd(OP_REGISTER, '0, 1'b0, '0, '0);
    send_cmd(OP_RUN, '0, 1'b0, '0, '0);
    for (int i = 0; i < SLOT_SPACE; i++) send_cmd(OP_UNREGISTER, i[SLOT_W-1:0], 1'b0, '0, '0);
    drain_results();
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int count);
    set_pacing(idle_pct, stall_pct);
    drive_random_cmds(count);
    drain_results();
  endtask

  // Block the output long enough that the input side has to stall
  task automatic test_output_backpressure();
    set_pacing(0, 0);
    hold_off_left = 300;
    drive_random_cmds(30);
    drain_results();
  endtask

  // Raise the sleep-hold count a few steps, then release it past zero
  task automatic test_hold_floor();
    set_pacing(0, 23);
    repeat (4) send_cmd(OP_HOLD, SLOT_W'($urandom_range(SLOT_SPACE - 1)), 1'b0, '0, '0);
    repeat (6) send_cmd(OP_RELEASE, '0, 1'b0, '0, '0);
    drain_results();
  endtask

  // Output ready: random stalls, plus a counted hold-off on request
  always @(posedge clk) begin
    if (hold_off_left > 0) begin
      m_tready <= 1'b0;
      hold_off_left = hold_off_left - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  task automatic report_field(input string name, input logic [TICK_W-1:0] e,
                              input logic [TICK_W-1:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, e, a);
      err_count++;
    end
  endtask

  // Compare each result transfer against the oldest prediction
  always @(posedge clk) begin : result_check
    sched_result_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual tdata %h tlast %b",
                 $time, m_tdata, m_tlast);
        err_count++;
      end else begin
        exp_r = pending_results.pop_front();
        report_field("slot_out",      TICK_W'(exp_r.slot_out),      TICK_W'(m_tdata[4:0]));
        report_field("slot_due",      TICK_W'(exp_r.slot_due),      TICK_W'(m_tdata[5]));
        report_field("status",        TICK_W'(exp_r.status),        TICK_W'(m_tdata[6]));
        report_field("last_flag",     TICK_W'(exp_r.last_flag),     TICK_W'(m_tlast));
        report_field("spin_time",     exp_r.spin_time,              m_tdata[70:7]);
        report_field("current_slot",  TICK_W'(exp_r.current_slot),  TICK_W'(m_tdata[75:71]));
        report_field("sleep_allowed", TICK_W'(exp_r.sleep_allowed), TICK_W'(m_tdata[76]));
      end
    end
  end

  initial begin
    #60_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    now_base = {$urandom, $urandom};
    test_basic_ops();
    test_full_table();
    test_random_traffic(0, 0, 80);
    test_random_traffic(79, 0, 70);
    test_random_traffic(0, 79, 70);
    test_random_traffic(23, 23, 70);
    test_output_backpressure();
    test_hold_floor();
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/dts_pkg.sv
rtl/core/dts_ctrl.sv
rtl/core/dts_dpath.sv
rtl/core/deadline_task_scheduler.sv
rtl/core/dts_checker.sv
dv/tb_top.sv
